>>> design/access_vector_cache_macros.svh
// Assertion macros for the access vector cache checker.
// Needs clk and arst_n in scope where a macro is used.
`ifndef ACCESS_VECTOR_CACHE_MACROS_SVH
`define ACCESS_VECTOR_CACHE_MACROS_SVH

// Same-cycle implication.
`define AVC_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("access_vector_cache: assertion failed");

// Next-cycle implication.
`define AVC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("access_vector_cache: assertion failed");

`endif

>>> design/avc_pkg.sv
// Shared types and constants for the access vector cache.
// No dependencies; used by every module of the block.
package avc_pkg;

	localparam int USED_W = 7;

	typedef enum logic [2:0] {
		ST_GRANTED     = 3'd0,
		ST_DENIED      = 3'd1,
		ST_OVERWRITTEN = 3'd2,
		ST_INSERTED    = 3'd3,
		ST_FULL        = 3'd4
	} avc_status_t;

	typedef enum logic {
		CMD_CHECK  = 1'b0,
		CMD_UPDATE = 1'b1
	} avc_cmd_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_BUSY = 1'b1
	} avc_state_t;

	typedef struct packed {
		logic [31:0] source_id;
		logic [31:0] target_id;
		logic [15:0] object_class;
	} avc_key_t;

	typedef struct packed {
		avc_cmd_t    cmd;
		logic [31:0] source_id;
		logic [31:0] target_id;
		logic [15:0] object_class;
		logic [31:0] perm_bits;
	} avc_in_t;

	typedef struct packed {
		avc_status_t       status;
		logic              hit;
		logic [USED_W-1:0] used_entries;
	} avc_out_t;

	// Lookup token handed from cell to cell.
	typedef struct packed {
		logic        vld;
		avc_cmd_t    cmd;
		avc_key_t    key;
		logic [31:0] perm;
		logic        found;
		logic        grant;
		logic        free_found;
	} avc_tok_t;

	// Insert broadcast from the chain end.
	typedef struct packed {
		logic        en;
		avc_key_t    key;
		logic [31:0] perm;
	} avc_ins_t;

endpackage

>>> design/avc_cell.sv
// One cache entry: valid bit, key and permission word, plus the token stage.
// Depends on avc_pkg.
module avc_cell import avc_pkg::*; #(
	parameter int IDX_W    = 6,
	parameter int CELL_IDX = 0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  avc_tok_t         tok_in,
	input  logic [IDX_W-1:0] idx_in,
	output avc_tok_t         tok_out,
	output logic [IDX_W-1:0] idx_out,
	input  avc_ins_t         ins,
	input  logic [IDX_W-1:0] ins_idx
);

	logic             valid_q;
	avc_key_t         key_q;
	logic [31:0]      perm_q;
	avc_tok_t         tok_q;
	logic [IDX_W-1:0] idx_q;

	logic             match;
	logic             take;
	logic             claim;
	logic             ins_here;
	avc_tok_t         tok_nx;
	logic [IDX_W-1:0] idx_nx;

	assign match    = valid_q && (key_q == tok_in.key);
	assign take     = tok_in.vld && match && !tok_in.found;
	assign claim    = tok_in.vld && !valid_q && !tok_in.free_found;
	assign ins_here = ins.en && (ins_idx == IDX_W'(CELL_IDX));

	always_comb begin
		tok_nx = tok_in;
		idx_nx = idx_in;
		if (take) begin
			tok_nx.found = 1'b1;
			tok_nx.grant = |(perm_q & tok_in.perm);
		end
		if (claim) begin
			tok_nx.free_found = 1'b1;
			idx_nx            = IDX_W'(CELL_IDX);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			tok_q   <= '0;
		end else begin
			tok_q <= tok_nx;
			if (ins_here) begin
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_q <= idx_nx;
		if (ins_here) begin
			key_q  <= ins.key;
			perm_q <= ins.perm;
		end else if (take && tok_in.cmd == CMD_UPDATE) begin
			perm_q <= tok_in.perm;
		end
	end

	assign tok_out = tok_q;
	assign idx_out = idx_q;

endmodule

>>> design/access_vector_cache.sv
// Access vector cache: top level, a row of entry cells with control at the ends.
// Depends on avc_pkg and avc_cell.
//
// Usage:
//   req channel (req_valid, req_stall, req_word) takes one word per item:
//   a check (cmd 0) or an update/insert (cmd 1) with a key and a permission
//   word. rsp channel (rsp_valid, rsp_stall, rsp_word) returns one word per
//   item: status, hit flag and the occupied entry count after the item.
//   A lookup token enters the first cell on accept and moves one cell per
//   cycle; each cell compares its key and notes the first free entry.
//   The response is registered as the token leaves the last cell.
//   The next item waits for the walk through the cell row; one item is in
//   flight at a time. An insert is written into the chosen cell as the
//   token leaves the row.
//   A new request is taken in the cycle the response is taken, so a
//   stalled response holds off the next request until it is taken.
//   Reset empties the table and clears the count; no clearing pass.
module access_vector_cache import avc_pkg::*; #(
	parameter int ENTRIES = 64
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	input  avc_in_t  req_word,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	output avc_out_t rsp_word
);

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam int EXT_W = CNT_W + USED_W;

	avc_tok_t         tok [ENTRIES+1];
	logic [IDX_W-1:0] idx [ENTRIES+1];

	avc_state_t       state_q;
	avc_state_t       state_nx;
	logic             rsp_valid_q;
	avc_out_t         rsp_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_nx;
	avc_ins_t         ins;
	avc_out_t         res;
	logic             done;
	logic             accept;
	logic [EXT_W-1:0] cnt_ext;

	assign done   = tok[ENTRIES].vld;
	assign accept = req_valid && !req_stall;

	always_comb begin
		tok[0]            = '0;
		tok[0].vld        = accept;
		tok[0].cmd        = req_word.cmd;
		tok[0].key        = '{source_id:    req_word.source_id,
		                      target_id:    req_word.target_id,
		                      object_class: req_word.object_class};
		tok[0].perm       = req_word.perm_bits;
		idx[0]            = '0;
	end

	for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
		avc_cell #(
			.IDX_W    (IDX_W),
			.CELL_IDX (k)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.tok_in  (tok[k]),
			.idx_in  (idx[k]),
			.tok_out (tok[k+1]),
			.idx_out (idx[k+1]),
			.ins     (ins),
			.ins_idx (idx[ENTRIES])
		);
	end

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_IDLE:  if (accept) state_nx = S_BUSY;
			S_BUSY:  if (done) state_nx = S_IDLE;
			default: state_nx = S_IDLE;
		endcase
	end

	// outputs and result
	always_comb begin
		req_stall = (state_q == S_BUSY) || (rsp_valid_q && rsp_stall);
		ins.en    = 1'b0;
		ins.key   = tok[ENTRIES].key;
		ins.perm  = tok[ENTRIES].perm;
		count_nx  = count_q;
		res.hit   = tok[ENTRIES].found;
		if (tok[ENTRIES].cmd == CMD_CHECK) begin
			res.status = (tok[ENTRIES].found && !tok[ENTRIES].grant) ? ST_DENIED : ST_GRANTED;
		end else if (tok[ENTRIES].found) begin
			res.status = ST_OVERWRITTEN;
		end else if (tok[ENTRIES].free_found) begin
			res.status = ST_INSERTED;
			ins.en     = done;
			count_nx   = count_q + CNT_W'(1);
		end else begin
			res.status = ST_FULL;
		end
		cnt_ext          = EXT_W'(count_nx);
		res.used_entries = cnt_ext[USED_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
			count_q     <= '0;
		end else begin
			state_q <= state_nx;
			if (done) begin
				rsp_valid_q <= 1'b1;
				count_q     <= count_nx;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_word  = rsp_q;

endmodule

>>> design/avc_checker.sv
// Port-level checker for the access vector cache, bound to the top level.
// Depends on avc_pkg and access_vector_cache_macros.svh.
`include "access_vector_cache_macros.svh"

module avc_checker import avc_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     req_valid,
	input logic     req_stall,
	input avc_in_t  req_word,
	input logic     rsp_valid,
	input logic     rsp_stall,
	input avc_out_t rsp_word
);

	`AVC_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_word))
	`AVC_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall)
	`AVC_ASSERT_NOW(a_overwrite_hits, rsp_valid && rsp_word.status == ST_OVERWRITTEN, rsp_word.hit)
	`AVC_ASSERT_NOW(a_denied_hits, rsp_valid && rsp_word.status == ST_DENIED, rsp_word.hit)
	`AVC_ASSERT_NOW(a_insert_misses,
		rsp_valid && (rsp_word.status == ST_INSERTED || rsp_word.status == ST_FULL),
		!rsp_word.hit)

endmodule

bind access_vector_cache avc_checker u_avc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.req_word  (req_word),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp_word  (rsp_word)
);
